>>> rtl/prea_pkg.sv
package prea_pkg;

  localparam int MAX_EXTENTS_DEF   = 16;
  localparam int PAGE_NUM_BITS_DEF = 20;

  localparam logic [1:0] CMD_ANY   = 2'd0;
  localparam logic [1:0] CMD_BELOW = 2'd1;
  localparam logic [1:0] CMD_AT    = 2'd2;
  localparam logic [1:0] CMD_FREE  = 2'd3;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_NO_SPACE  = 3'd2;
  localparam logic [2:0] ST_NOT_FOUND = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CHECK,
    S_SCAN_RD,
    S_SCAN_EV,
    S_SETUP,
    S_RD_PREV,
    S_GET_PREV,
    S_RD_NEXT,
    S_GET_NEXT,
    S_PLAN,
    S_SHIFT_RD,
    S_SHIFT_WR,
    S_PIECE,
    S_DONE
  } state_t;

  typedef struct packed {
    logic latch;
    logic pre;
    logic scan_rd;
    logic scan_ev;
    logic setup;
    logic rd_prev;
    logic get_prev;
    logic rd_next;
    logic get_next;
    logic plan;
    logic shift_rd;
    logic shift_wr;
    logic piece_wr;
  } dp_cmd_t;

  typedef struct packed {
    logic pre_fail;
    logic scan_last;
    logic found;
    logic full;
    logic shift_more;
    logic piece_last;
  } dp_stat_t;

endpackage

>>> rtl/prea_ctrl.sv
module prea_ctrl import prea_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     start,
  input  dp_stat_t stat,
  output dp_cmd_t  ctl,
  output logic     busy,
  output logic     done
);

  state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    ctl        = '0;
    busy       = (state != S_IDLE);
    done       = (state == S_DONE);
    case (state)
      S_IDLE: begin
        if (start) begin
          ctl.latch  = 1'b1;
          state_next = S_CHECK;
        end
      end
      S_CHECK: begin
        ctl.pre    = 1'b1;
        state_next = stat.pre_fail ? S_DONE : S_SCAN_RD;
      end
      S_SCAN_RD: begin
        ctl.scan_rd = 1'b1;
        state_next  = S_SCAN_EV;
      end
      S_SCAN_EV: begin
        ctl.scan_ev = 1'b1;
        state_next  = stat.scan_last ? S_SETUP : S_SCAN_RD;
      end
      S_SETUP: begin
        ctl.setup  = 1'b1;
        state_next = stat.found ? S_RD_PREV : S_DONE;
      end
      S_RD_PREV: begin
        ctl.rd_prev = 1'b1;
        state_next  = S_GET_PREV;
      end
      S_GET_PREV: begin
        ctl.get_prev = 1'b1;
        state_next   = S_RD_NEXT;
      end
      S_RD_NEXT: begin
        ctl.rd_next = 1'b1;
        state_next  = S_GET_NEXT;
      end
      S_GET_NEXT: begin
        ctl.get_next = 1'b1;
        state_next   = S_PLAN;
      end
      S_PLAN: begin
        ctl.plan   = 1'b1;
        state_next = stat.full ? S_DONE : S_SHIFT_RD;
      end
      S_SHIFT_RD: begin
        if (stat.shift_more) begin
          ctl.shift_rd = 1'b1;
          state_next   = S_SHIFT_WR;
        end else begin
          state_next = S_PIECE;
        end
      end
      S_SHIFT_WR: begin
        ctl.shift_wr = 1'b1;
        state_next   = S_SHIFT_RD;
      end
      S_PIECE: begin
        ctl.piece_wr = 1'b1;
        if (stat.piece_last) state_next = S_DONE;
      end
      S_DONE: begin
        state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

endmodule

>>> rtl/prea_dp.sv
module prea_dp import prea_pkg::*; #(
  parameter int MAX_EXTENTS   = MAX_EXTENTS_DEF,
  parameter int PAGE_NUM_BITS = PAGE_NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic [1:0]  cmd,
  input  logic [19:0] page,
  input  logic [20:0] npages,
  input  dp_cmd_t     ctl,
  output dp_stat_t    stat,
  output logic [2:0]  status,
  output logic [19:0] result_page
);

  localparam int PB = PAGE_NUM_BITS;
  localparam int IW = $clog2(MAX_EXTENTS);
  localparam int CW = $clog2(MAX_EXTENTS + 3);
  localparam int AW = ((PB > 21) ? PB : 21) + 1;
  localparam logic [AW-1:0] TOP = AW'((64'd1 << PB) - 64'd1);

  // extent table, kept sorted and merged in entries 0..n-1
  logic [PB-1:0] mem_start [MAX_EXTENTS];
  logic [PB-1:0] mem_last  [MAX_EXTENTS];
  logic          mem_alloc [MAX_EXTENTS];

  logic [PB-1:0] rd_start, rd_last;
  logic          rd_alloc;
  logic [IW-1:0] raddr, waddr;
  logic          we;
  logic [PB-1:0] wd_start, wd_last;
  logic          wd_alloc;

  logic [1:0]    cmd_r;
  logic [AW-1:0] pg, cnt, lim, s, e, best;
  logic          a, found;
  logic [IW-1:0] bi;
  logic [PB-1:0] ent_s, ent_l, prev_s, next_l;
  logic [CW-1:0] n, j, p1, newn, wptr;
  logic          lft, rgt, mlft, mrgt, up;
  logic [1:0]    q;
  logic [2:0]    st;

  logic          is_alloc;
  logic [AW-1:0] e_fix, lim_c, rs, rl, end_c;
  logic [2:0]    pre_st;
  logic          fit, hit, fix_ok;
  logic          lft_c, rgt_c, mlft_c, mrgt_c, hp, hn;
  logic [CW-1:0] bi_w, newn_c, p0_c, p1_c, dest;
  logic          full_c;
  logic          pc_en;
  logic [PB-1:0] pc_start, pc_last;
  logic          pc_alloc;

  assign is_alloc = (cmd_r == CMD_ANY) || (cmd_r == CMD_BELOW);
  assign e_fix    = pg + cnt - AW'(1);

  always_comb begin
    if (cmd_r == CMD_ANY) lim_c = TOP;
    else if (pg == '0)    lim_c = '0;
    else                  lim_c = pg - AW'(1);
    if (cnt == '0)                pre_st = ST_INVALID;
    else if (is_alloc)            pre_st = (lim_c == '0) ? ST_NO_SPACE : ST_OK;
    else if (e_fix > TOP)         pre_st = ST_INVALID;
    else if (pg == '0)            pre_st = ST_NOT_FOUND;
    else                          pre_st = ST_OK;
  end

  // scan evaluation of one entry
  assign rs     = AW'(rd_start);
  assign rl     = AW'(rd_last);
  assign end_c  = (rl < lim) ? rl : lim;
  assign fit    = !rd_alloc && (rs <= lim) && (end_c - rs + AW'(1) >= cnt)
                  && (!found || end_c > best);
  assign hit    = (rs <= s) && (s <= rl);
  assign fix_ok = (rd_alloc != a) && (e <= rl);

  // edit plan around extent bi
  assign bi_w   = CW'(bi);
  assign lft_c  = s > AW'(ent_s);
  assign rgt_c  = e < AW'(ent_l);
  assign hp     = (bi_w != '0);
  assign hn     = (bi_w != n - CW'(1));
  assign mlft_c = !lft_c && hp;
  assign mrgt_c = !rgt_c && hn;
  assign newn_c = n + CW'(lft_c) + CW'(rgt_c) - CW'(mlft_c) - CW'(mrgt_c);
  assign full_c = newn_c > CW'(MAX_EXTENTS);
  assign p0_c   = bi_w - CW'(mlft_c);
  assign p1_c   = bi_w + CW'(mrgt_c);
  assign dest   = j + newn - n;

  always_comb begin
    case (q)
      2'd0: begin
        pc_en    = lft;
        pc_start = ent_s;
        pc_last  = PB'(s - AW'(1));
        pc_alloc = !a;
      end
      2'd1: begin
        pc_en    = 1'b1;
        pc_start = mlft ? prev_s : PB'(s);
        pc_last  = mrgt ? next_l : PB'(e);
        pc_alloc = a;
      end
      default: begin
        pc_en    = rgt;
        pc_start = PB'(e + AW'(1));
        pc_last  = ent_l;
        pc_alloc = !a;
      end
    endcase
  end

  always_comb begin
    raddr = j[IW-1:0];
    if (ctl.rd_prev)      raddr = bi - IW'(1);
    else if (ctl.rd_next) raddr = bi + IW'(1);
    we       = 1'b0;
    waddr    = dest[IW-1:0];
    wd_start = rd_start;
    wd_last  = rd_last;
    wd_alloc = rd_alloc;
    if (ctl.shift_wr) begin
      we = 1'b1;
    end else if (ctl.piece_wr && pc_en) begin
      we       = 1'b1;
      waddr    = wptr[IW-1:0];
      wd_start = pc_start;
      wd_last  = pc_last;
      wd_alloc = pc_alloc;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mem_start[0] <= PB'(1);
      mem_last[0]  <= '1;
      mem_alloc[0] <= 1'b0;
    end else if (we) begin
      mem_start[waddr] <= wd_start;
      mem_last[waddr]  <= wd_last;
      mem_alloc[waddr] <= wd_alloc;
    end
  end

  always_ff @(posedge clk) begin
    rd_start <= mem_start[raddr];
    rd_last  <= mem_last[raddr];
    rd_alloc <= mem_alloc[raddr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      n     <= CW'(1);
      st    <= ST_OK;
      found <= 1'b0;
    end else begin
      if (ctl.latch) begin
        cmd_r <= cmd;
        pg    <= AW'(PB'(page));
        cnt   <= AW'(npages);
      end
      if (ctl.pre) begin
        st    <= pre_st;
        lim   <= lim_c;
        s     <= pg;
        e     <= e_fix;
        a     <= (cmd_r != CMD_FREE);
        found <= 1'b0;
        j     <= '0;
      end
      if (ctl.scan_ev) begin
        j <= j + CW'(1);
        if (is_alloc ? fit : hit) begin
          bi    <= j[IW-1:0];
          ent_s <= rd_start;
          ent_l <= rd_last;
          best  <= end_c;
          found <= is_alloc ? 1'b1 : fix_ok;
        end
      end
      if (ctl.setup) begin
        if (is_alloc) begin
          s <= best - cnt + AW'(1);
          e <= best;
        end
        if (!found) st <= is_alloc ? ST_NO_SPACE : ST_NOT_FOUND;
      end
      if (ctl.get_prev) prev_s <= rd_start;
      if (ctl.get_next) next_l <= rd_last;
      if (ctl.plan) begin
        lft  <= lft_c;
        rgt  <= rgt_c;
        mlft <= mlft_c;
        mrgt <= mrgt_c;
        p1   <= p1_c;
        newn <= newn_c;
        wptr <= p0_c;
        q    <= '0;
        up   <= newn_c > n;
        // tail moves from the top down when it grows, else from the bottom up
        j    <= (newn_c > n) ? n - CW'(1) : p1_c + CW'(1);
        if (full_c) st <= ST_FULL;
      end
      if (ctl.shift_wr) j <= up ? j - CW'(1) : j + CW'(1);
      if (ctl.piece_wr) begin
        q <= q + 2'd1;
        if (pc_en) wptr <= wptr + CW'(1);
        if (q == 2'd2) n <= newn;
      end
    end
  end

  assign stat.pre_fail   = (pre_st != ST_OK);
  assign stat.scan_last  = (j == n - CW'(1));
  assign stat.found      = found;
  assign stat.full       = full_c;
  assign stat.shift_more = (newn != n) && (up ? (j != p1) : (j < n));
  assign stat.piece_last = (q == 2'd2);

  assign status      = st;
  assign result_page = (st == ST_OK && cmd_r != CMD_FREE) ? 20'(s) : 20'd0;

endmodule

>>> rtl/page_range_extent_allocator_core.sv
// channel   | ports                          | handshake
// ----------+--------------------------------+-----------------------------
// command   | cmd, page, npages              | taken when start && !busy
// result    | status, result_page            | one cycle on done, no stall
//
// one command at a time; busy stays high from the accepting edge to done.
// the time per word grows with n, the extents in the table, and t, the extents
// moved; the extent table, read one entry at a time, sets it.
// rejected words end after the check, the scan or the plan.
// rst is synchronous: table holds one free extent from page 1 to the top.
// the receiver cannot stall; done marks status for exactly one cycle.
module page_range_extent_allocator_core import prea_pkg::*; #(
  parameter int MAX_EXTENTS   = MAX_EXTENTS_DEF,
  parameter int PAGE_NUM_BITS = PAGE_NUM_BITS_DEF
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  cmd,
  input  logic [19:0] page,
  input  logic [20:0] npages,
  output logic        done,
  output logic [2:0]  status,
  output logic [19:0] result_page
);

  dp_cmd_t  ctl;
  dp_stat_t stat;

  prea_ctrl u_ctrl (
    .clk   (clk),
    .rst   (rst),
    .start (start),
    .stat  (stat),
    .ctl   (ctl),
    .busy  (busy),
    .done  (done)
  );

  prea_dp #(
    .MAX_EXTENTS   (MAX_EXTENTS),
    .PAGE_NUM_BITS (PAGE_NUM_BITS)
  ) u_dp (
    .clk         (clk),
    .rst         (rst),
    .cmd         (cmd),
    .page        (page),
    .npages      (npages),
    .ctl         (ctl),
    .stat        (stat),
    .status      (status),
    .result_page (result_page)
  );

endmodule

>>> rtl/prea_chk.sv
module prea_chk import prea_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        start,
  input logic        busy,
  input logic        done,
  input logic [2:0]  status,
  input logic [19:0] result_page
);

  // a taken word keeps the block busy
  a_accept_busy: assert property (@(posedge clk) disable iff (rst)
    start && !busy |=> busy)
    else $error("busy not raised after accept");

  // result only shows while a word is in flight
  a_done_busy: assert property (@(posedge clk) disable iff (rst)
    done |-> busy)
    else $error("done without a word in flight");

  // one result per word: done is not held and the block is idle after it
  a_done_once: assert property (@(posedge clk) disable iff (rst)
    done |=> !busy && !done)
    else $error("done held or block still busy");

  a_status_code: assert property (@(posedge clk) disable iff (rst)
    done |-> status <= ST_FULL)
    else $error("bad status code");

  a_fail_page: assert property (@(posedge clk) disable iff (rst)
    done && status != ST_OK |-> result_page == 20'd0)
    else $error("page reported on failure");

endmodule

bind page_range_extent_allocator_core prea_chk u_prea_chk (
  .clk         (clk),
  .rst         (rst),
  .start       (start),
  .busy        (busy),
  .done        (done),
  .status      (status),
  .result_page (result_page)
);

>>> sim/page_range_extent_allocator_core_test.sv
`timescale 1ns / 1ps

module page_range_extent_allocator_core_test;
  import prea_pkg::*;

  localparam int EXTENTS = MAX_EXTENTS_DEF;
  localparam bit [22:0] TOP = 23'd1048575;
  localparam int IDLE_LIMIT = 3000;

  typedef struct {
    logic [1:0]  cmd;
    logic [19:0] page;
    logic [20:0] count;
  } page_cmd_t;

  typedef struct {
    logic [2:0]  status;
    logic [19:0] first;
  } page_reply_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic start = 1'b0;
  logic busy;
  logic [1:0] cmd = CMD_ANY;
  logic [19:0] page = '0;
  logic [20:0] npages = '0;
  logic done;
  logic [2:0] status;
  logic [19:0] result_page;

  page_range_extent_allocator_core DUT (
    .clk(clk), .rst(rst), .start(start), .busy(busy),
    .cmd(cmd), .page(page), .npages(npages),
    .done(done), .status(status), .result_page(result_page)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // extent table kept sorted and merged, as the block leaves it
  bit [22:0] ext_first [EXTENTS];
  bit [22:0] ext_last [EXTENTS];
  bit        ext_alloc [EXTENTS];
  int        ext_n;

  page_cmd_t   pending_words[$];
  page_reply_t expected_replies[$];
  page_cmd_t   cur_word;
  int issued = 0, accepted = 0, replies = 0, errors = 0, idle_cycles = 0;
  int burst_left = 0, gap_left = 0;
  int n_ok = 0, n_full = 0, n_notfound = 0, n_nospace = 0;

  function automatic logic [2:0] convert_range(bit [22:0] s, bit [22:0] e, bit a);
    bit [22:0] ns [3*EXTENTS+3];
    bit [22:0] nl [3*EXTENTS+3];
    bit        na [3*EXTENTS+3];
    bit [22:0] covered, lo, hi;
    int cnt;
    covered = 0;
    cnt = 0;
    for (int i = 0; i < ext_n; i++) begin
      if (ext_last[i] < s || ext_first[i] > e) continue;
      if (ext_alloc[i] == a) return ST_NOT_FOUND;
      lo = ext_first[i] > s ? ext_first[i] : s;
      hi = ext_last[i] < e ? ext_last[i] : e;
      covered += hi - lo + 23'd1;
    end
    if (covered != e - s + 23'd1) return ST_NOT_FOUND;
    for (int i = 0; i < ext_n; i++) begin
      bit [22:0] ps [3];
      bit [22:0] pl [3];
      bit        pa [3];
      int np;
      np = 0;
      if (ext_last[i] < s || ext_first[i] > e) begin
        ps[0] = ext_first[i]; pl[0] = ext_last[i]; pa[0] = ext_alloc[i]; np = 1;
      end else begin
        if (ext_first[i] < s) begin
          ps[np] = ext_first[i]; pl[np] = s - 23'd1; pa[np] = ext_alloc[i]; np++;
        end
        ps[np] = ext_first[i] > s ? ext_first[i] : s;
        pl[np] = ext_last[i] < e ? ext_last[i] : e;
        pa[np] = a;
        np++;
        if (ext_last[i] > e) begin
          ps[np] = e + 23'd1; pl[np] = ext_last[i]; pa[np] = ext_alloc[i]; np++;
        end
      end
      for (int k = 0; k < np; k++) begin
        if (cnt > 0 && na[cnt-1] == pa[k] && nl[cnt-1] + 23'd1 == ps[k]) begin
          nl[cnt-1] = pl[k];
        end else begin
          ns[cnt] = ps[k]; nl[cnt] = pl[k]; na[cnt] = pa[k]; cnt++;
        end
      end
    end
    if (cnt > EXTENTS) return ST_FULL;
    for (int i = 0; i < cnt; i++) begin
      ext_first[i] = ns[i]; ext_last[i] = nl[i]; ext_alloc[i] = na[i];
    end
    ext_n = cnt;
    return ST_OK;
  endfunction

  function automatic page_reply_t predict_reply(page_cmd_t w);
    page_reply_t r;
    bit [22:0] lim, best, e, fit_end, first;
    bit found;
    r.status = ST_OK;
    first = 0;
    if (w.count == 0) begin
      r.status = ST_INVALID;
    end else if (w.cmd == CMD_ANY || w.cmd == CMD_BELOW) begin
      lim = TOP;
      if (w.cmd == CMD_BELOW) lim = (w.page == 0) ? 23'd0 : 23'(w.page) - 23'd1;
      found = 1'b0;
      best = 0;
      for (int i = 0; i < ext_n; i++) begin
        if (ext_alloc[i] || ext_first[i] > lim) continue;
        fit_end = ext_last[i] < lim ? ext_last[i] : lim;
        if (fit_end - ext_first[i] + 23'd1 < 23'(w.count)) continue;
        if (!found || fit_end > best) begin
          best = fit_end;
          found = 1'b1;
        end
      end
      if (lim == 0 || !found) begin
        r.status = ST_NO_SPACE;
      end else begin
        first = best - 23'(w.count) + 23'd1;
        r.status = convert_range(first, first + 23'(w.count) - 23'd1, 1'b1);
      end
    end else begin
      e = 23'(w.page) + 23'(w.count) - 23'd1;
      if (e > TOP) r.status = ST_INVALID;
      else if (w.page == 0) r.status = ST_NOT_FOUND;
      else if (w.cmd == CMD_AT) begin
        r.status = convert_range(23'(w.page), e, 1'b1);
        first = 23'(w.page);
      end else begin
        r.status = convert_range(23'(w.page), e, 1'b0);
      end
    end
    r.first = (r.status == ST_OK && w.cmd != CMD_FREE) ? first[19:0] : 20'd0;
    return r;
  endfunction

  task automatic queue_word(logic [1:0] c, logic [19:0] p, logic [20:0] n);
    page_cmd_t w;
    w.cmd = c;
    w.page = p;
    w.count = n;
    pending_words.push_back(w);
  endtask

  // driver: changes inputs on the falling edge
  always @(negedge clk) begin
    if (!rst && (!start || accepted == issued)) begin
      if (gap_left > 0) begin
        gap_left <= gap_left - 1;
        start <= 1'b0;
      end else if (pending_words.size() > 0) begin
        cur_word = pending_words.pop_front();
        cmd <= cur_word.cmd;
        page <= cur_word.page;
        npages <= cur_word.count;
        start <= 1'b1;
        issued <= issued + 1;
        if (burst_left > 0) begin
          burst_left <= burst_left - 1;
        end else begin
          burst_left <= $urandom_range(0, 12);
          gap_left <= ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 40);
        end
      end else begin
        start <= 1'b0;
      end
    end
  end

  // monitor: results first, then the word taken on this edge
  always @(posedge clk) begin
    page_cmd_t w;
    page_reply_t exp_r;
    if (!rst) begin
      if (done) begin
        replies++;
        if (expected_replies.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected result: status %0d page %0d",
                                     status, result_page);
        end else begin
          exp_r = expected_replies.pop_front();
          if (status !== exp_r.status || result_page !== exp_r.first) begin
            errors++;
            if (errors <= 10)
              $display("mismatch: status exp %0d got %0d, page exp %0d got %0d",
                       exp_r.status, status, exp_r.first, result_page);
          end
        end
      end
      if (start && !busy) begin
        w.cmd = cmd;
        w.page = page;
        w.count = npages;
        exp_r = predict_reply(w);
        case (exp_r.status)
          ST_OK:        n_ok++;
          ST_FULL:      n_full++;
          ST_NOT_FOUND: n_notfound++;
          ST_NO_SPACE:  n_nospace++;
          default: ;
        endcase
        expected_replies.push_back(exp_r);
        accepted <= accepted + 1;
      end
      if (done || (start && !busy)) idle_cycles <= 0;
      else idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= IDLE_LIMIT) begin
        $display("timeout waiting on the block");
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    logic [19:0] at_page [$];
    logic [20:0] at_count [$];
    int pick, k, sel;
    logic [19:0] p;
    logic [20:0] n;
    ext_n = 1;
    ext_first[0] = 23'd1;
    ext_last[0] = TOP;
    ext_alloc[0] = 1'b0;

    // directed: extremes, rejects, table full
    queue_word(CMD_ANY, 20'd0, 21'd0);
    queue_word(CMD_FREE, 20'hFFFFF, 21'd0);
    queue_word(CMD_ANY, 20'd0, 21'd1048576);
    queue_word(CMD_ANY, 20'd0, 21'd1048575);
    queue_word(CMD_AT, 20'd5, 21'd1);
    queue_word(CMD_FREE, 20'd1, 21'd1048575);
    queue_word(CMD_AT, 20'hFFFFF, 21'd1);
    queue_word(CMD_AT, 20'hFFFFF, 21'd2);
    queue_word(CMD_FREE, 20'hFFFFF, 21'd1);
    queue_word(CMD_AT, 20'd0, 21'd3);
    queue_word(CMD_FREE, 20'd100, 21'd1);
    queue_word(CMD_BELOW, 20'd0, 21'd1);
    queue_word(CMD_BELOW, 20'd1, 21'd1);
    queue_word(CMD_BELOW, 20'd2, 21'd1);
    queue_word(CMD_FREE, 20'd1, 21'd1);
    for (int i = 0; i < 8; i++) queue_word(CMD_AT, 20'(10 + 2 * i), 21'd1);
    queue_word(CMD_ANY, 20'd0, 21'd4);
    for (int i = 0; i < 7; i++) queue_word(CMD_FREE, 20'(10 + 2 * i), 21'd1);

    // random: mostly allocate/free pairs in two small windows
    for (int i = 0; i < 800; i++) begin
      sel = $urandom_range(0, 99);
      n = 21'($urandom_range(1, ($urandom_range(0, 7) == 0) ? 40 : 6));
      if (sel < 35) begin
        p = ($urandom_range(0, 1)) ? 20'($urandom_range(1, 200))
                                   : 20'($urandom_range(1048330, 1048575));
        queue_word(CMD_AT, p, n);
        at_page.push_back(p);
        at_count.push_back(n);
      end else if (sel < 60 && at_page.size() > 0) begin
        pick = $urandom_range(0, at_page.size() - 1);
        queue_word(CMD_FREE, at_page[pick], at_count[pick]);
        at_page.delete(pick);
        at_count.delete(pick);
      end else if (sel < 70) begin
        queue_word(CMD_ANY, 20'($urandom), n);
      end else if (sel < 80) begin
        queue_word(CMD_BELOW, ($urandom_range(0, 1)) ? 20'($urandom_range(0, 260))
                                                     : 20'($urandom), n);
      end else if (sel < 88) begin
        queue_word(CMD_FREE, 20'($urandom_range(1048300, 1048575)), n);
      end else begin
        k = $urandom_range(0, 3);
        queue_word(2'(k), 20'($urandom), ($urandom_range(0, 1)) ? 21'($urandom)
                                                                 : 21'($urandom_range(0, 300)));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;
    wait (pending_words.size() == 0 && accepted == issued && !start &&
          expected_replies.size() == 0);
    repeat (100) @(posedge clk);
    $display("%0d commands checked: %0d ok, %0d table full, %0d wrong range, %0d no space",
             accepted, n_ok, n_full, n_notfound, n_nospace);
    $display("%0d results compared, %0d mismatches", replies, errors);
    if (errors == 0 && expected_replies.size() == 0) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule
